// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Both sample on clk and are off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Precondition this cycle, consequence in the next cycle.
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// File: rtl/hss_pkg.sv
`default_nettype none

package hss_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int TRACK_BITS  = 16;

  localparam int IDX_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
  localparam int LEAVES   = 1 << $clog2(QUEUE_DEPTH);
  // key MSB set = entry not eligible
  localparam int KEY_BITS = TRACK_BITS + 1;

  typedef logic [TRACK_BITS-1:0]  track_t;
  typedef logic [IDX_BITS-1:0]    idx_t;
  typedef logic [CNT_BITS-1:0]    cnt_t;
  typedef logic [KEY_BITS-1:0]    key_t;
  typedef logic [QUEUE_DEPTH-1:0] mask_t;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_START   = 1'b1;
  localparam logic STATUS_ENTRY = 1'b0;
  localparam logic STATUS_FULL  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_EMIT_START,
    ST_LO_KEY,
    ST_LO_TREE,
    ST_HI_KEY,
    ST_HI_TREE,
    ST_DECIDE,
    ST_KEY,
    ST_PICK
  } state_t;

  typedef enum logic [1:0] {
    KEY_NEAR,
    KEY_LOW,
    KEY_HIGH
  } key_mode_t;

  typedef struct packed {
    logic      load_write;
    logic      emit_reject;
    logic      start_latch;
    logic      classify;
    logic      emit_start;
    logic      key_load;
    key_mode_t key_mode;
    logic      capture_lo;
    logic      capture_hi;
    logic      decide;
    logic      toggle_side;
    logic      emit_pick;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
    logic store_full;
    logic no_pending;
    logic found;
    logic pick_last;
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/hss_ctrl.sv
`default_nettype none

module hss_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_kind,
  output logic               in_stall,
  input  wire hss_pkg::sts_t sts,
  output hss_pkg::cmd_t      cmd
);

  hss_pkg::state_t state_r, state_nxt;
  logic accept;

  assign accept = (state_r == hss_pkg::ST_IDLE) && in_valid && !sts.out_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hss_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hss_pkg::ST_IDLE: begin
        if (accept && (in_kind == hss_pkg::KIND_START)) state_nxt = hss_pkg::ST_CLASSIFY;
      end
      hss_pkg::ST_CLASSIFY: state_nxt = hss_pkg::ST_EMIT_START;
      hss_pkg::ST_EMIT_START: begin
        if (!sts.out_busy) begin
          state_nxt = sts.no_pending ? hss_pkg::ST_IDLE : hss_pkg::ST_LO_KEY;
        end
      end
      hss_pkg::ST_LO_KEY:  state_nxt = hss_pkg::ST_LO_TREE;
      hss_pkg::ST_LO_TREE: state_nxt = hss_pkg::ST_HI_KEY;
      hss_pkg::ST_HI_KEY:  state_nxt = hss_pkg::ST_HI_TREE;
      hss_pkg::ST_HI_TREE: state_nxt = hss_pkg::ST_DECIDE;
      hss_pkg::ST_DECIDE:  state_nxt = hss_pkg::ST_KEY;
      hss_pkg::ST_KEY:     state_nxt = hss_pkg::ST_PICK;
      hss_pkg::ST_PICK: begin
        if (!sts.found) begin
          state_nxt = hss_pkg::ST_KEY;
        end else if (!sts.out_busy) begin
          state_nxt = sts.pick_last ? hss_pkg::ST_IDLE : hss_pkg::ST_KEY;
        end
      end
      default: state_nxt = hss_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.key_mode = hss_pkg::KEY_NEAR;
    in_stall     = 1'b1;
    unique case (state_r)
      hss_pkg::ST_IDLE: begin
        in_stall        = sts.out_busy;
        cmd.load_write  = accept && (in_kind == hss_pkg::KIND_LOAD) && !sts.store_full;
        cmd.emit_reject = accept && (in_kind == hss_pkg::KIND_LOAD) && sts.store_full;
        cmd.start_latch = accept && (in_kind == hss_pkg::KIND_START);
      end
      hss_pkg::ST_CLASSIFY:   cmd.classify   = 1'b1;
      hss_pkg::ST_EMIT_START: cmd.emit_start = !sts.out_busy;
      hss_pkg::ST_LO_KEY: begin
        cmd.key_load = 1'b1;
        cmd.key_mode = hss_pkg::KEY_LOW;
      end
      hss_pkg::ST_LO_TREE: cmd.capture_lo = 1'b1;
      hss_pkg::ST_HI_KEY: begin
        cmd.key_load = 1'b1;
        cmd.key_mode = hss_pkg::KEY_HIGH;
      end
      hss_pkg::ST_HI_TREE: cmd.capture_hi = 1'b1;
      hss_pkg::ST_DECIDE:  cmd.decide     = 1'b1;
      hss_pkg::ST_KEY: begin
        cmd.key_load = 1'b1;
        cmd.key_mode = hss_pkg::KEY_NEAR;
      end
      hss_pkg::ST_PICK: begin
        cmd.toggle_side = !sts.found;
        cmd.emit_pick   = sts.found && !sts.out_busy;
      end
      default: in_stall = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/hss_dpath.sv
`default_nettype none

`include "assert_macros.svh"

module hss_dpath (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire hss_pkg::cmd_t   cmd,
  output hss_pkg::sts_t        sts,
  input  wire hss_pkg::track_t in_request_track,
  input  wire hss_pkg::track_t in_start_track,
  input  wire logic            out_stall,
  output logic                 out_valid,
  output hss_pkg::track_t      out_served_track,
  output logic                 out_status,
  output logic                 out_last
);

  localparam int QD = hss_pkg::QUEUE_DEPTH;
  localparam int LV = hss_pkg::LEAVES;
  localparam int TB = hss_pkg::TRACK_BITS;
  localparam int KB = hss_pkg::KEY_BITS;
  localparam int CB = hss_pkg::CNT_BITS;
  localparam int IB = hss_pkg::IDX_BITS;

  function automatic hss_pkg::track_t absdiff(hss_pkg::track_t a, hss_pkg::track_t b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  hss_pkg::track_t track_r [QD];
  hss_pkg::key_t   key_r   [QD];
  hss_pkg::key_t   key_nxt [QD];
  hss_pkg::cnt_t   count_r;
  hss_pkg::track_t head_r, lowest_r, highest_r;
  hss_pkg::mask_t  low_r, high_r, done_r;
  hss_pkg::mask_t  low_nxt, high_nxt;
  logic            want_high_r, want_high_nxt;

  logic            out_valid_r;
  hss_pkg::track_t out_track_r;
  logic            out_status_r, out_last_r;

  // min tree, heap order: node n merges 2n and 2n+1, left wins ties
  hss_pkg::key_t node_key [2*LV];
  hss_pkg::idx_t node_idx [2*LV];

  logic            found, pick_last, no_pending, emit_any, clear_store;
  hss_pkg::idx_t   pick_idx;
  hss_pkg::track_t pick_track;
  hss_pkg::mask_t  done_next;

  always_comb begin
    node_key[0] = '1;
    node_idx[0] = '0;
    for (int i = 0; i < LV; i++) begin
      if (i < QD) begin
        node_key[LV+i] = key_r[i];
        node_idx[LV+i] = IB'(i);
      end else begin
        node_key[LV+i] = '1;
        node_idx[LV+i] = '0;
      end
    end
    for (int n = LV - 1; n >= 1; n--) begin
      if (node_key[2*n+1] < node_key[2*n]) begin
        node_key[n] = node_key[2*n+1];
        node_idx[n] = node_idx[2*n+1];
      end else begin
        node_key[n] = node_key[2*n];
        node_idx[n] = node_idx[2*n];
      end
    end
  end

  assign found      = !node_key[1][KB-1];
  assign pick_idx   = node_idx[1];
  assign pick_track = track_r[pick_idx];
  assign done_next  = done_r | (hss_pkg::mask_t'(1) << pick_idx);
  assign pick_last  = ~|((low_r | high_r) & ~done_next);
  assign no_pending = ~|(low_r | high_r);
  assign emit_any   = cmd.emit_reject | cmd.emit_start | cmd.emit_pick;
  assign clear_store = (cmd.emit_start && no_pending) || (cmd.emit_pick && pick_last);

  // per-entry keys and side split, all lanes independent
  always_comb begin
    for (int i = 0; i < QD; i++) begin
      logic occupied;
      logic elig;
      hss_pkg::track_t val;
      occupied = CB'(i) < count_r;
      low_nxt[i]  = occupied && (track_r[i] < head_r);
      high_nxt[i] = occupied && (track_r[i] > head_r);
      case (cmd.key_mode)
        hss_pkg::KEY_LOW: begin
          elig = low_r[i];
          val  = track_r[i];
        end
        hss_pkg::KEY_HIGH: begin
          elig = high_r[i];
          val  = ~track_r[i];
        end
        default: begin
          elig = (want_high_r ? high_r[i] : low_r[i]) && !done_r[i];
          val  = absdiff(track_r[i], head_r);
        end
      endcase
      key_nxt[i] = {!elig, val};
    end
  end

  assign want_high_nxt = !(|low_r) ||
                         ((|high_r) && ((head_r - lowest_r) > (highest_r - head_r)));

  always_ff @(posedge clk) begin
    if (cmd.load_write) track_r[count_r[IB-1:0]] <= in_request_track;
    if (cmd.key_load) begin
      for (int i = 0; i < QD; i++) key_r[i] <= key_nxt[i];
    end
    if (cmd.capture_lo) lowest_r  <= node_key[1][TB-1:0];
    if (cmd.capture_hi) highest_r <= ~node_key[1][TB-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      head_r      <= '0;
      low_r       <= '0;
      high_r      <= '0;
      done_r      <= '0;
      want_high_r <= 1'b0;
    end else begin
      if (clear_store) begin
        count_r <= '0;
      end else if (cmd.load_write) begin
        count_r <= count_r + CB'(1);
      end
      if (cmd.start_latch) head_r <= in_start_track;
      if (cmd.classify) begin
        low_r  <= low_nxt;
        high_r <= high_nxt;
        done_r <= '0;
      end
      if (cmd.decide) want_high_r <= want_high_nxt;
      if (cmd.toggle_side) want_high_r <= !want_high_r;
      if (cmd.emit_pick) begin
        head_r <= pick_track;
        done_r <= done_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_any) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_reject) begin
      out_track_r  <= in_request_track;
      out_status_r <= hss_pkg::STATUS_FULL;
      out_last_r   <= 1'b1;
    end else if (cmd.emit_start) begin
      out_track_r  <= head_r;
      out_status_r <= hss_pkg::STATUS_ENTRY;
      out_last_r   <= no_pending;
    end else if (cmd.emit_pick) begin
      out_track_r  <= pick_track;
      out_status_r <= hss_pkg::STATUS_ENTRY;
      out_last_r   <= pick_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_served_track = out_track_r;
  assign out_status       = out_status_r;
  assign out_last         = out_last_r;

  assign sts.out_busy   = out_valid_r && out_stall;
  assign sts.store_full = (count_r == CB'(QD));
  assign sts.no_pending = no_pending;
  assign sts.found      = found;
  assign sts.pick_last  = pick_last;

  `ASSERT_CLK(a_emit_free, emit_any |-> !(out_valid_r && out_stall), "word overwrote a held result")
  `ASSERT_CLK(a_count_range, count_r <= CB'(QD), "fill count beyond store depth")
  `ASSERT_CLK(a_pick_found, cmd.emit_pick |-> found, "pick emitted with no eligible entry")
  `ASSERT_NEXT(a_run_clears, clear_store, count_r == '0, "store not emptied after final word")

endmodule

`default_nettype wire

// File: rtl/hybrid_sstf_disk_scheduler.sv
// Two-sided shortest-seek-first track scheduler.
// Input channel (in_valid/in_stall): a kind 0 word loads in_request_track into
//   the next free slot of a 32-entry store and gives no result;
//   into a full store it gives one word: the track, status 1, last 1.
// A kind 1 word starts a run at in_start_track: the first result is the start
//   position, then every stored track in service order, last set on the final
//   word. Tracks equal to the start are dropped. The run then empties the store.
// Output channel (out_valid/out_stall): one output register; a stalled word
//   holds and the scheduler waits before loading the next one.
// Sequence, no stall: the start word is registered out after the classify step;
//   lowest/highest search and side choice follow, then each served track takes
//   a key register load and one pass through a 32-leaf min tree, plus one more
//   load and pass at the switch to the second side. A run with nothing to serve
//   ends after the start word. Input is stalled for the whole run.
// Reset (rst_n, synchronous, active low) empties the store via its fill count
//   and drops any pending result.
`default_nettype none

module hybrid_sstf_disk_scheduler (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_kind,
  input  wire logic [hss_pkg::TRACK_BITS-1:0] in_request_track,
  input  wire logic [hss_pkg::TRACK_BITS-1:0] in_start_track,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [hss_pkg::TRACK_BITS-1:0]     out_served_track,
  output logic                               out_status,
  output logic                               out_last
);

  // controller <-> datapath
  hss_pkg::cmd_t cmd;
  hss_pkg::sts_t sts;

  // sequencer: accepts words, steps through split, side choice and picks
  hss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // store, key lanes, min tree and output register
  hss_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_request_track (in_request_track),
    .in_start_track   (in_start_track),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_served_track (out_served_track),
    .out_status       (out_status),
    .out_last         (out_last)
  );

endmodule

`default_nettype wire
